// ===== rtl/mttb_pkg.sv =====
package mttb_pkg;

    // Field widths fixed by the item format.
    localparam int TIMER_WIDTH = 16;
    localparam int VALUE_W     = 16;
    localparam int MS_W        = 10;
    localparam int SEC_W       = 6;
    localparam int MIN_W       = 16;
    localparam int IDX_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_TIMERS  = 13;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    typedef logic [IDX_W-1:0]       timer_idx_t;

    // Item operations.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Timer slots.
    localparam timer_idx_t T_SLEEP   = 4'd0;
    localparam timer_idx_t T_PAUSE   = 4'd1;
    localparam timer_idx_t T_AD      = 4'd2;
    localparam timer_idx_t T_KEYSCAN = 4'd3;
    localparam timer_idx_t T_LED     = 4'd4;
    localparam timer_idx_t T_PAIRING = 4'd5;
    localparam timer_idx_t T_DOUBLE  = 4'd6;
    localparam timer_idx_t T_SHORT   = 4'd7;
    localparam timer_idx_t T_CHARGE  = 4'd8;
    localparam timer_idx_t T_POWER   = 4'd9;
    localparam timer_idx_t T_HANDLE  = 4'd10;
    localparam timer_idx_t T_VOLMAX  = 4'd11;
    localparam timer_idx_t T_LOWBAT  = 4'd12;
    localparam timer_idx_t T_LAST    = 4'(NUM_TIMERS - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_SECOND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_PER_MINUTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PERIOD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LOW      = 3'd5;

    // Configuration reset values.
    localparam logic [MS_W-1:0]    RST_MS_PER_SECOND  = 10'd1000;
    localparam logic [SEC_W-1:0]   RST_SEC_PER_MINUTE = 6'd60;
    localparam logic [VALUE_W-1:0] RST_SLEEP_LIMIT    = 16'd20;
    localparam logic [MS_W-1:0]    RST_KEY_PERIOD     = 10'd80;
    localparam logic [VALUE_W-1:0] RST_PULSE_HIGH     = 16'd500;
    localparam logic [VALUE_W-1:0] RST_PULSE_LOW      = 16'd250;

    // How each timer counts on a tick.
    typedef enum logic [2:0] {
        KIND_SLEEP,
        KIND_PAUSE,
        KIND_FLAG,
        KIND_ZERO,
        KIND_ONE,
        KIND_DOUBLE
    } kind_t;

    function automatic kind_t timer_kind(input timer_idx_t idx);
        kind_t k;
        case (idx)
            T_SLEEP:                             k = KIND_SLEEP;
            T_PAUSE:                             k = KIND_PAUSE;
            T_AD, T_KEYSCAN, T_LED:              k = KIND_FLAG;
            T_DOUBLE:                            k = KIND_DOUBLE;
            T_SHORT, T_HANDLE, T_LOWBAT:         k = KIND_ONE;
            default:                             k = KIND_ZERO;
        endcase
        return k;
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOCK,
        ST_WALK,
        ST_APPLY,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [IDX_W-1:0]   timer_index;
        logic [VALUE_W-1:0] load_value;
        logic               power_on;
    } in_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] timer_value;
        logic               ad_task;
        logic               scan_task;
        logic               blink_task;
        logic               key_tick;
        logic               answer_level;
        logic [MS_W-1:0]    millisecond;
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       clock_step;
        logic       walk_en;
        timer_idx_t walk_idx;
        logic       apply;
        logic       load_out;
    } cmd_t;

endpackage

// ===== rtl/mttb_ctrl.sv =====
module mttb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           is_tick,
    input  logic           out_ready,
    output logic           in_ready,
    output logic           out_valid,
    output mttb_pkg::cmd_t cmd
);

    mttb_pkg::state_t     state_reg, state_next;
    mttb_pkg::timer_idx_t walk_idx_reg, walk_idx_next;
    logic                 out_valid_reg, out_valid_next;

    // State, walk counter and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mttb_pkg::ST_IDLE;
            walk_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_idx_reg  <= walk_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        walk_idx_next  = walk_idx_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.walk_idx   = walk_idx_reg;

        unique case (state_reg)
            mttb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = is_tick ? mttb_pkg::ST_CLOCK : mttb_pkg::ST_APPLY;
                end
            end
            mttb_pkg::ST_CLOCK:
            begin
                cmd.clock_step = 1'b1;
                walk_idx_next  = '0;
                state_next     = mttb_pkg::ST_WALK;
            end
            mttb_pkg::ST_WALK:
            begin
                cmd.walk_en = 1'b1;
                if (walk_idx_reg == mttb_pkg::T_LAST)
                begin
                    state_next = mttb_pkg::ST_RESULT;
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + 1'b1;
                end
            end
            mttb_pkg::ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = mttb_pkg::ST_RESULT;
            end
            mttb_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = mttb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mttb_pkg::ST_IDLE;
            end
        endcase

        // The output register holds a beat until it is taken.
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // The walk never runs past the last timer.
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mttb_pkg::ST_WALK) |-> (walk_idx_reg <= mttb_pkg::T_LAST))
        else $error("timer walk index out of range");

    // The clock step always hands over to a walk that starts at the first timer.
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mttb_pkg::ST_CLOCK) |=>
            (state_reg == mttb_pkg::ST_WALK && walk_idx_reg == '0))
        else $error("walk did not start at timer zero");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    // One item at a time: no beat is taken in the cycle after an accept.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while busy");
`endif

endmodule

// ===== rtl/mttb_dpath.sv =====
module mttb_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mttb_pkg::cmd_t                       cmd,
    input  mttb_pkg::in_beat_t                   in_data,
    input  logic                                 cfg_we,
    input  logic [mttb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mttb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output mttb_pkg::out_beat_t                  out_data
);

    // Configuration registers.
    logic [mttb_pkg::MS_W-1:0]    ms_per_second_reg;
    logic [mttb_pkg::SEC_W-1:0]   sec_per_minute_reg;
    logic [mttb_pkg::VALUE_W-1:0] sleep_limit_reg;
    logic [mttb_pkg::MS_W-1:0]    key_period_reg;
    logic [mttb_pkg::VALUE_W-1:0] pulse_high_reg;
    logic [mttb_pkg::VALUE_W-1:0] pulse_low_reg;

    // Latched item.
    logic [1:0]                   op_reg;
    mttb_pkg::timer_idx_t         idx_reg;
    logic [mttb_pkg::VALUE_W-1:0] load_reg;
    logic                         power_reg;

    // Wall clock and timer state.
    logic [mttb_pkg::MS_W-1:0]    ms_reg, ms_next;
    logic [mttb_pkg::SEC_W-1:0]   sec_reg, sec_next;
    logic [mttb_pkg::MIN_W-1:0]   min_reg, min_next;
    logic                         sec_roll_reg, sec_roll_next;
    logic                         min_roll_reg, min_roll_next;
    mttb_pkg::timer_t             store_reg [mttb_pkg::NUM_TIMERS];
    logic                         drive_reg, drive_next;

    // Per-tick flags and the key-period remainder.
    logic                         ad_flag_reg, ad_flag_next;
    logic                         key_flag_reg, key_flag_next;
    logic                         led_flag_reg, led_flag_next;
    logic [mttb_pkg::MS_W-1:0]    rem_reg, rem_next;

    mttb_pkg::out_beat_t          out_reg;

    // Walk datapath signals.
    mttb_pkg::timer_t             cur;
    mttb_pkg::timer_t             upd;
    mttb_pkg::timer_t             dec;
    logic                         hit;
    logic [mttb_pkg::MS_W:0]      ms_inc;
    logic [mttb_pkg::SEC_W:0]     sec_inc;
    logic [3:0]                   bit_sel;
    logic [mttb_pkg::MS_W:0]      trial;
    logic                         store_we;
    mttb_pkg::timer_idx_t         store_addr;
    mttb_pkg::timer_t             store_wdata;
    logic                         idx_ok;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_per_second_reg  <= mttb_pkg::RST_MS_PER_SECOND;
            sec_per_minute_reg <= mttb_pkg::RST_SEC_PER_MINUTE;
            sleep_limit_reg    <= mttb_pkg::RST_SLEEP_LIMIT;
            key_period_reg     <= mttb_pkg::RST_KEY_PERIOD;
            pulse_high_reg     <= mttb_pkg::RST_PULSE_HIGH;
            pulse_low_reg      <= mttb_pkg::RST_PULSE_LOW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mttb_pkg::CFG_MS_PER_SECOND:  ms_per_second_reg  <= cfg_data[mttb_pkg::MS_W-1:0];
                mttb_pkg::CFG_SEC_PER_MINUTE: sec_per_minute_reg <= cfg_data[mttb_pkg::SEC_W-1:0];
                mttb_pkg::CFG_SLEEP_LIMIT:    sleep_limit_reg    <= cfg_data;
                mttb_pkg::CFG_KEY_PERIOD:     key_period_reg     <= cfg_data[mttb_pkg::MS_W-1:0];
                mttb_pkg::CFG_PULSE_HIGH:     pulse_high_reg     <= cfg_data;
                mttb_pkg::CFG_PULSE_LOW:      pulse_low_reg      <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Item latch.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= in_data.operation;
            idx_reg   <= in_data.timer_index;
            load_reg  <= in_data.load_value;
            power_reg <= in_data.power_on;
        end
    end

    assign idx_ok = (idx_reg < mttb_pkg::IDX_W'(mttb_pkg::NUM_TIMERS));

    // Wall clock advance for one tick.
    always_comb
    begin
        ms_next       = ms_reg;
        sec_next      = sec_reg;
        min_next      = min_reg;
        sec_roll_next = sec_roll_reg;
        min_roll_next = min_roll_reg;
        ms_inc        = {1'b0, ms_reg} + 1'b1;
        sec_inc       = {1'b0, sec_reg} + 1'b1;
        if (cmd.clock_step)
        begin
            sec_roll_next = 1'b0;
            min_roll_next = 1'b0;
            if (ms_inc[mttb_pkg::MS_W-1:0] >= ms_per_second_reg)
            begin
                ms_next       = '0;
                sec_roll_next = 1'b1;
                if (sec_inc[mttb_pkg::SEC_W-1:0] >= sec_per_minute_reg)
                begin
                    sec_next      = '0;
                    min_next      = min_reg + 1'b1;
                    min_roll_next = 1'b1;
                end
                else
                begin
                    sec_next = sec_inc[mttb_pkg::SEC_W-1:0];
                end
            end
            else
            begin
                ms_next = ms_inc[mttb_pkg::MS_W-1:0];
            end
        end
    end

    // Update of the timer under the walk pointer.
    always_comb
    begin
        cur           = store_reg[cmd.walk_idx];
        dec           = cur - 1'b1;
        upd           = cur;
        hit           = 1'b0;
        drive_next    = drive_reg;
        ad_flag_next  = ad_flag_reg;
        key_flag_next = key_flag_reg;
        led_flag_next = led_flag_reg;

        case (mttb_pkg::timer_kind(cmd.walk_idx))
            mttb_pkg::KIND_SLEEP:
            begin
                if (min_roll_reg && power_reg && (32'(cur) < 32'(sleep_limit_reg)))
                begin
                    upd = cur + 1'b1;
                end
            end
            mttb_pkg::KIND_PAUSE:
            begin
                if (sec_roll_reg && cur != '0)
                begin
                    upd = dec;
                end
            end
            mttb_pkg::KIND_FLAG:
            begin
                if (cur != '0)
                begin
                    upd = dec;
                    hit = (dec == '0);
                end
            end
            mttb_pkg::KIND_ZERO:
            begin
                if (cur != '0)
                begin
                    upd = dec;
                end
            end
            mttb_pkg::KIND_ONE:
            begin
                if (cur > mttb_pkg::TIMER_WIDTH'(1))
                begin
                    upd = dec;
                end
            end
            mttb_pkg::KIND_DOUBLE:
            begin
                if (cur > mttb_pkg::TIMER_WIDTH'(1))
                begin
                    upd = dec;
                    if (cmd.walk_en)
                    begin
                        // High, then low, then high again as the count runs down.
                        if (32'(dec) >= 32'(pulse_high_reg))
                        begin
                            drive_next = 1'b1;
                        end
                        else if (32'(dec) >= 32'(pulse_low_reg))
                        begin
                            drive_next = 1'b0;
                        end
                        else
                        begin
                            drive_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                upd = cur;
            end
        endcase

        if (cmd.accept)
        begin
            ad_flag_next  = 1'b0;
            key_flag_next = 1'b0;
            led_flag_next = 1'b0;
        end
        else if (cmd.walk_en)
        begin
            case (cmd.walk_idx)
                mttb_pkg::T_AD:      ad_flag_next  = hit;
                mttb_pkg::T_KEYSCAN: key_flag_next = hit;
                mttb_pkg::T_LED:     led_flag_next = hit;
                default:             ;
            endcase
        end
    end

    // Key period remainder, one bit of the millisecond count per walk step.
    always_comb
    begin
        bit_sel  = 4'(mttb_pkg::MS_W - 1) - cmd.walk_idx;
        trial    = {rem_reg, ms_reg[bit_sel]};
        rem_next = rem_reg;
        if (cmd.clock_step)
        begin
            rem_next = '0;
        end
        else if (cmd.walk_en && cmd.walk_idx < 4'(mttb_pkg::MS_W))
        begin
            if (trial >= {1'b0, key_period_reg})
            begin
                rem_next = mttb_pkg::MS_W'(trial - {1'b0, key_period_reg});
            end
            else
            begin
                rem_next = trial[mttb_pkg::MS_W-1:0];
            end
        end
    end

    // Timer store write port: the walk, or a write item.
    always_comb
    begin
        store_we    = 1'b0;
        store_addr  = cmd.walk_idx;
        store_wdata = upd;
        if (cmd.walk_en)
        begin
            store_we = 1'b1;
        end
        else if (cmd.apply && op_reg == mttb_pkg::OP_WRITE && idx_ok)
        begin
            store_we    = 1'b1;
            store_addr  = idx_reg;
            store_wdata = mttb_pkg::TIMER_WIDTH'(load_reg);
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg       <= '0;
            sec_reg      <= '0;
            min_reg      <= '0;
            sec_roll_reg <= 1'b0;
            min_roll_reg <= 1'b0;
            drive_reg    <= 1'b0;
            ad_flag_reg  <= 1'b0;
            key_flag_reg <= 1'b0;
            led_flag_reg <= 1'b0;
            rem_reg      <= '0;
            for (int i = 0; i < mttb_pkg::NUM_TIMERS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            ms_reg       <= ms_next;
            sec_reg      <= sec_next;
            min_reg      <= min_next;
            sec_roll_reg <= sec_roll_next;
            min_roll_reg <= min_roll_next;
            drive_reg    <= drive_next;
            ad_flag_reg  <= ad_flag_next;
            key_flag_reg <= key_flag_next;
            led_flag_reg <= led_flag_next;
            rem_reg      <= rem_next;
            if (store_we)
            begin
                store_reg[store_addr] <= store_wdata;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.timer_value    <= idx_ok ? mttb_pkg::VALUE_W'(store_reg[idx_reg]) : '0;
            out_reg.ad_task        <= ad_flag_reg;
            out_reg.scan_task      <= key_flag_reg;
            out_reg.blink_task     <= led_flag_reg;
            out_reg.key_tick       <= (op_reg == mttb_pkg::OP_TICK) &&
                                      (key_period_reg == '0 || rem_reg == '0);
            out_reg.answer_level   <= drive_reg;
            out_reg.millisecond    <= ms_reg;
            out_reg.second         <= sec_reg;
            out_reg.minute         <= min_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/millisecond_tick_timer_bank.sv =====
// Channel  | Signals                         | Beat contents
// ---------+---------------------------------+-------------------------------------------
// in       | in_valid, in_ready, in_data     | operation, timer_index, load_value, power_on
// out      | out_valid, out_ready, out_data  | timer value, task flags, key tick, clock
// cfg      | cfg_we, cfg_index, cfg_data     | one of six registers, written at once
//
// A tick runs through accept, one wall clock step, a walk over the 13 timers
// through one shared update unit (one timer per cycle), and a result load.
// The key period remainder is worked out one bit per walk cycle alongside it.
// A write or read runs accept, apply and a result load. One item is in work at a time;
// the next one is accepted while the previous result still waits in the output register.
// Reset clears the clock, all timers and the answer level, and loads the defaults.
module millisecond_tick_timer_bank (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  mttb_pkg::in_beat_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mttb_pkg::out_beat_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [mttb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mttb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mttb_pkg::cmd_t cmd;
    logic           is_tick;

    // Only a tick runs the clock step and the timer walk.
    assign is_tick = (in_data.operation == mttb_pkg::OP_TICK);

    mttb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .is_tick   (is_tick),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mttb_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule
